FILE: rtl/core/cdn_pkg.sv
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types, constants and calendar tables for the day number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cdn_pkg;

	localparam int unsigned DN_W    = 22;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned QUOT_W  = 12;  // 4-year block count, below 4096
	localparam int unsigned BIT_W   = 1;   // divider phase
	localparam int unsigned RECIP_SHIFT = 32;

	localparam logic [DN_W-1:0]   DAYS_PER_4Y    = 22'd1461;
	// ceil(2^32 / 1461), exact for every 22-bit dividend
	localparam logic [DN_W-1:0]   DAYS_PER_4Y_RECIP = 22'd2939745;
	localparam logic [DN_W-1:0]   DAY_NUMBER_MAX = 22'd3652500;
	localparam logic [YEAR_W-1:0] YEAR_MAX       = 14'd9999;
	localparam logic [8:0]        DAYS_LEAP_YEAR = 9'd366;
	localparam logic [8:0]        DAYS_YEAR      = 9'd365;
	localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic MODE_TO_DN   = 1'b0;
	localparam logic MODE_TO_DATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIX,
		ST_YEAR,
		ST_MONTH,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV,
		CMD_FIX,
		CMD_YEAR,
		CMD_MONTH,
		CMD_ADD,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic err;
		logic div_last;
		logic year_done;
		logic month_done;
	} status_t;

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		case (m) inside
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [8:0] d;
		d = 9'd0;
		case (m)
			MON_JAN: d = 9'd0;
			MON_FEB: d = 9'd31;
			MON_MAR: d = 9'd59;
			MON_APR: d = 9'd90;
			MON_MAY: d = 9'd120;
			MON_JUN: d = 9'd151;
			MON_JUL: d = 9'd181;
			MON_AUG: d = 9'd212;
			MON_SEP: d = 9'd243;
			MON_OCT: d = 9'd273;
			MON_NOV: d = 9'd304;
			MON_DEC: d = 9'd334;
			default: d = 9'd0;
		endcase
		if (m >= MON_MAR && leap)
			d = d + 9'd1;
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/calendar_day_number_converter.sv
// ----------------------------------------------------------------------------
// calendar_day_number_converter
// Converts a date to a serial day number and back; day 1 is year 0 Jan 1.
//
// Channel   Dir  Payload
// s_*       in   tuser: mode; tdata: day_number, year, month, day
// m_*       out  tuser: error; tdata: day_number_out, year_out, month_out, day_out
//
// One request at a time. Date to day number runs check, add and output states.
// Day number to date runs check, the reciprocal divider by 1461 (quotient,
// then remainder), a fix step, up to 3 year steps and up to 11 month steps.
// A request with an out-of-range year or day number skips to its error result.
// A finished result sits in the output register while the next request is
// accepted; the sequencer stalls in its last state only if that register is full.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_day_number_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [47:0] s_tdata,   // day_number[21:0], year[35:22], month[39:36], day[44:40]
	input  wire logic [0:0]  s_tuser,   // mode[0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [47:0] m_tdata,   // day_number_out[21:0], year_out[35:22],
	                                    // month_out[39:36], day_out[44:40]
	output      logic [0:0]  m_tuser    // error[0]
);
	import cdn_pkg::*;

	cmd_t               cmd;
	status_t            status;
	logic [DN_W-1:0]    dn_out;
	logic [YEAR_W-1:0]  year_out;
	logic [MONTH_W-1:0] month_out;
	logic [DAY_W-1:0]   day_out;
	logic               err_out;

	cdn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cdn_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode_in   (s_tuser[0]),
		.dn_in     (s_tdata[21:0]),
		.year_in   (s_tdata[35:22]),
		.month_in  (s_tdata[39:36]),
		.day_in    (s_tdata[44:40]),
		.dn_out    (dn_out),
		.year_out  (year_out),
		.month_out (month_out),
		.day_out   (day_out),
		.err_out   (err_out)
	);

	assign m_tdata = {3'b000, day_out, month_out, year_out, dn_out};
	assign m_tuser = err_out;

endmodule

`default_nettype wire

FILE: rtl/core/cdn_datapath.sv
// ----------------------------------------------------------------------------
// cdn_datapath
// Working registers, block divider, year and month stepping, day number sum, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdn_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cdn_pkg::cmd_t                  cmd,
	output      cdn_pkg::status_t               status,
	input  wire logic                           mode_in,
	input  wire logic [cdn_pkg::DN_W-1:0]       dn_in,
	input  wire logic [cdn_pkg::YEAR_W-1:0]     year_in,
	input  wire logic [cdn_pkg::MONTH_W-1:0]    month_in,
	input  wire logic [cdn_pkg::DAY_W-1:0]      day_in,
	output      logic [cdn_pkg::DN_W-1:0]       dn_out,
	output      logic [cdn_pkg::YEAR_W-1:0]     year_out,
	output      logic [cdn_pkg::MONTH_W-1:0]    month_out,
	output      logic [cdn_pkg::DAY_W-1:0]      day_out,
	output      logic                           err_out
);
	import cdn_pkg::*;

	logic [DN_W-1:0]    acc_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [BIT_W-1:0]   bit_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic               mode_q;
	logic               err_q;

	logic [2*DN_W-1:0]  recip_prod;
	logic [DN_W-1:0]    block_days;
	logic [DN_W:0]      prod;
	logic               leap;
	logic [8:0]         year_len;
	logic [DAY_W-1:0]   mon_len;
	logic [YEAR_W-1:0]  block_year;
	logic [DN_W-1:0]    leap_days;
	logic [DN_W-1:0]    dn_sum;
	logic               month_ok;
	logic               load_err;

	// quotient by 1461 through the scaled reciprocal, remainder from the registered quotient in the following cycle
	assign recip_prod = (2*DN_W)'(acc_q) * (2*DN_W)'(DAYS_PER_4Y_RECIP);
	assign block_days = DN_W'(quot_q) * DAYS_PER_4Y;
	assign prod       = (DN_W+1)'(year_in) * (DN_W+1)'(DAYS_YEAR);
	assign leap       = year_q[1:0] == 2'b00;
	assign year_len   = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
	assign mon_len    = month_length(month_q, leap);
	assign block_year = {quot_q, 2'b00};
	assign month_ok   = month_q >= MONTH_FIRST && month_q <= MONTH_LAST;
	assign load_err   = mode_in ? (dn_in == '0 || dn_in > DAY_NUMBER_MAX) : (year_in > YEAR_MAX);

	// leap days before this year: one for year 0, then one every four years
	assign leap_days = (year_q != '0) ? DN_W'((year_q - 14'd1) >> 2) + 22'd1 : '0;
	assign dn_sum    = acc_q + leap_days + DN_W'(day_q) + DN_W'(days_before(month_q, leap));

	assign status.mode       = mode_q;
	assign status.err        = err_q;
	assign status.div_last   = bit_q == '0;
	assign status.year_done  = acc_q <= DN_W'(year_len);
	assign status.month_done = acc_q <= DN_W'(mon_len) || month_q == MONTH_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			err_q     <= 1'b0;
			acc_q     <= '0;
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			quot_q    <= '0;
			bit_q     <= '0;
			dn_out    <= '0;
			year_out  <= '0;
			month_out <= '0;
			day_out   <= '0;
			err_out   <= 1'b0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					mode_q  <= mode_in;
					err_q   <= load_err;
					// date to day number starts from year * 365
					acc_q   <= mode_in ? dn_in : prod[DN_W-1:0];
					year_q  <= year_in;
					month_q <= month_in;
					day_q   <= day_in;
					quot_q  <= '0;
					bit_q   <= BIT_W'(1);
				end
				CMD_DIV: begin
					if (bit_q != '0)
						quot_q <= recip_prod[RECIP_SHIFT +: QUOT_W];
					else
						acc_q <= acc_q - block_days;
					bit_q <= bit_q - BIT_W'(1);
				end
				CMD_FIX: begin
					month_q <= MONTH_FIRST;
					// remainder zero is the last day of the previous block
					if (acc_q == '0) begin
						year_q <= block_year - 14'd1;
						acc_q  <= DN_W'(DAYS_YEAR);
					end else begin
						year_q <= block_year;
					end
				end
				CMD_YEAR: begin
					acc_q  <= acc_q - DN_W'(year_len);
					year_q <= year_q + 14'd1;
				end
				CMD_MONTH: begin
					acc_q   <= acc_q - DN_W'(mon_len);
					month_q <= month_q + 4'd1;
				end
				CMD_ADD: begin
					acc_q <= month_ok ? dn_sum : '0;
				end
				CMD_OUT: begin
					dn_out    <= (mode_q == MODE_TO_DN && !err_q) ? acc_q : '0;
					year_out  <= (mode_q == MODE_TO_DATE && !err_q) ? year_q : '0;
					month_out <= (mode_q == MODE_TO_DATE && !err_q) ? month_q : '0;
					day_out   <= (mode_q == MODE_TO_DATE && !err_q) ? acc_q[DAY_W-1:0] : '0;
					err_out   <= err_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/cdn_ctrl.sv
// ----------------------------------------------------------------------------
// cdn_ctrl
// Sequencer for the converter and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cdn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire cdn_pkg::status_t  status,
	output      cdn_pkg::cmd_t     cmd
);
	import cdn_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = ST_CHECK;
			ST_CHECK: begin
				if (status.err)
					state_nxt = ST_DONE;
				else if (status.mode == MODE_TO_DATE)
					state_nxt = ST_DIV;
				else
					state_nxt = ST_ADD;
			end
			ST_DIV:   if (status.div_last) state_nxt = ST_FIX;
			ST_FIX:   state_nxt = ST_YEAR;
			ST_YEAR:  if (status.year_done) state_nxt = ST_MONTH;
			ST_MONTH: if (status.month_done) state_nxt = ST_DONE;
			ST_ADD:   state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = CMD_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd = CMD_LOAD;
			end
			ST_CHECK: cmd = CMD_NONE;
			ST_DIV:   cmd = CMD_DIV;
			ST_FIX:   cmd = CMD_FIX;
			ST_YEAR:  if (!status.year_done) cmd = CMD_YEAR;
			ST_MONTH: if (!status.month_done) cmd = CMD_MONTH;
			ST_ADD:   cmd = CMD_ADD;
			// hold the finished result until the output register frees up
			ST_DONE:  if (out_free) cmd = CMD_OUT;
			default:  cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd == CMD_OUT)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: verif/cdn_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdn_checker
// Watches both stream channels of the day number converter. Each accepted
// request is converted to its expected date or day number, and each accepted
// result is compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module cdn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // day_number[21:0], year[35:22], month[39:36], day[44:40]
	input  logic [0:0]  s_tuser,   // mode[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // day_number_out[21:0], year_out[35:22],
	                               // month_out[39:36], day_out[44:40]
	input  logic [0:0]  m_tuser,   // error[0]
	output int          fail_count,
	output int          pending
);
	import cdn_pkg::*;

	typedef struct packed {
		logic               mode;
		logic [DN_W-1:0]    dn;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mon;
		logic [DAY_W-1:0]   dy;
	} conv_req_t;

	typedef struct packed {
		logic [DN_W-1:0]    dn;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mon;
		logic [DAY_W-1:0]   dy;
		logic               err;
	} conv_res_t;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned DAYS_AHEAD [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	conv_res_t expected_dates [$];
	int        result_idx;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic int unsigned year_days(input int unsigned y);
		return (y % 4 == 0) ? int'(DAYS_LEAP_YEAR) : int'(DAYS_YEAR);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		if (m == MON_FEB && y % 4 == 0)
			return 29;
		return MONTH_DAYS[m-1];
	endfunction

	function automatic conv_res_t convert_request(input conv_req_t q);
		conv_res_t   r;
		int unsigned y;
		int unsigned m;
		int unsigned total;
		int unsigned dnv;
		int unsigned yy;
		int unsigned mm;
		int unsigned rem;
		r = '0;
		if (q.mode == MODE_TO_DN) begin
			if (q.yr > YEAR_MAX) begin
				r.err = 1'b1;
			end else if (q.mon >= MONTH_FIRST && q.mon <= MONTH_LAST) begin
				y = q.yr;
				m = q.mon;
				total = (y == 0) ? 0 : y * 365 + (y - 1) / 4 + 1;
				total = total + q.dy + DAYS_AHEAD[m-1];
				if (m >= MON_MAR && y % 4 == 0)
					total = total + 1;
				r.dn = total[DN_W-1:0];
			end
		end else begin
			dnv = q.dn;
			if (dnv == 0 || dnv > DAY_NUMBER_MAX) begin
				r.err = 1'b1;
			end else begin
				yy = (dnv / DAYS_PER_4Y) * 4;
				rem = dnv % DAYS_PER_4Y;
				// a block boundary lands on the last day of the previous year
				if (rem == 0) begin
					yy = yy - 1;
					rem = year_days(yy);
				end
				while (rem > year_days(yy)) begin
					rem = rem - year_days(yy);
					yy = yy + 1;
				end
				mm = 1;
				while (mm < 12 && rem > days_in_month(yy, mm)) begin
					rem = rem - days_in_month(yy, mm);
					mm = mm + 1;
				end
				r.yr = yy[YEAR_W-1:0];
				r.mon = mm[MONTH_W-1:0];
				r.dy = rem[DAY_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int idx, input longint got,
			input longint want);
		$display("[%0t] result %0d: %s is %0d, want %0d", $realtime, idx, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		conv_req_t q;
		conv_res_t want;
		conv_res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.dn = m_tdata[21:0];
				got.yr = m_tdata[35:22];
				got.mon = m_tdata[39:36];
				got.dy = m_tdata[44:40];
				got.err = m_tuser[0];
				if (expected_dates.size() == 0) begin
					report_mismatch("unrequested result, day_number_out", result_idx,
						got.dn, 0);
				end else begin
					want = expected_dates.pop_front();
					if (got.dn !== want.dn)
						report_mismatch("day_number_out", result_idx, got.dn, want.dn);
					if (got.yr !== want.yr)
						report_mismatch("year_out", result_idx, got.yr, want.yr);
					if (got.mon !== want.mon)
						report_mismatch("month_out", result_idx, got.mon, want.mon);
					if (got.dy !== want.dy)
						report_mismatch("day_out", result_idx, got.dy, want.dy);
					if (got.err !== want.err)
						report_mismatch("error", result_idx, got.err, want.err);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready) begin
				q.mode = s_tuser[0];
				q.dn = s_tdata[21:0];
				q.yr = s_tdata[35:22];
				q.mon = s_tdata[39:36];
				q.dy = s_tdata[44:40];
				expected_dates.push_back(convert_request(q));
			end
			pending = expected_dates.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives date and day number requests into the converter: a directed set of
// boundary dates first, then random requests in bursts while the result side
// stalls on its own pattern. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import cdn_pkg::*;

	localparam int RANDOM_ITEMS   = 900;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_TIGHT
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // day_number[21:0], year[35:22], month[39:36], day[44:40]
	logic [0:0]  s_tuser = '0;   // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // day_number_out[21:0], year_out[35:22],
	                             // month_out[39:36], day_out[44:40]
	logic [0:0]  m_tuser;        // error[0]

	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          n_to_dn = 0;
	int          n_to_date = 0;
	int          n_out_of_range = 0;
	rx_style_t   rx_style = RX_OPEN;
	int          rx_style_left = 0;

	calendar_day_number_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cdn_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// switch between open, coin-flip and mostly-stalled stretches
	always @(posedge clk) begin
		if (rx_style_left == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 2));
			rx_style_left <= $urandom_range(20, 300);
		end else begin
			rx_style_left <= rx_style_left - 1;
		end
		case (rx_style)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic mode, input logic [DN_W-1:0] dn,
			input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mon,
			input logic [DAY_W-1:0] dy);
		s_tdata <= {3'b000, dy, mon, yr, dn};
		s_tuser <= mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_TO_DN) begin
			n_to_dn++;
			if (yr > YEAR_MAX)
				n_out_of_range++;
		end else begin
			n_to_date++;
			if (dn == 0 || dn > DAY_NUMBER_MAX)
				n_out_of_range++;
		end
	endtask

	// hold valid low until every result has come back
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int          burst_left;
		int          gap;
		int          pick;
		logic        mode;
		logic [21:0] dn;
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dy;
		int unsigned k;

		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// date to day number: range ends, leap years, bad months, unchecked days
		send_request(MODE_TO_DN, '0, 14'd0, MON_JAN, 5'd1);
		send_request(MODE_TO_DN, '0, 14'd9999, MON_DEC, 5'd31);
		send_request(MODE_TO_DN, '0, 14'd10000, 4'd0, 5'd1);
		send_request(MODE_TO_DN, 22'h3FFFFF, 14'h3FFF, 4'hF, 5'h1F);
		send_request(MODE_TO_DN, '0, 14'd4, 4'd0, 5'd10);
		send_request(MODE_TO_DN, '0, 14'd2023, 4'd13, 5'd10);
		send_request(MODE_TO_DN, '0, 14'd2023, 4'd15, 5'd10);
		send_request(MODE_TO_DN, '0, 14'd2020, MON_MAR, 5'd0);
		send_request(MODE_TO_DN, '0, 14'd2023, MON_FEB, 5'd31);
		send_request(MODE_TO_DN, '0, 14'd2000, MON_MAR, 5'd1);
		send_request(MODE_TO_DN, '0, 14'd1, MON_JAN, 5'd1);
		send_request(MODE_TO_DN, '0, 14'd0, MON_DEC, 5'd31);
		// day number to date: zero, block boundaries, year ends, out of range
		send_request(MODE_TO_DATE, 22'd0, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd1, 14'h3FFF, 4'hF, 5'h1F);
		send_request(MODE_TO_DATE, 22'd60, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd366, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd367, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd1461, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd1462, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd2922, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd3652500, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'd3652501, '0, '0, '0);
		send_request(MODE_TO_DATE, 22'h3FFFFF, '0, '0, '0);
		wait_all_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 300 == 150)
				wait_all_results();
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;

			// unused fields carry random content in both modes
			dn = 22'($urandom());
			yr = 14'($urandom());
			mon = 4'($urandom());
			dy = 5'($urandom());
			pick = $urandom_range(0, 19);
			mode = (pick < 9) ? MODE_TO_DN : MODE_TO_DATE;
			case (pick)
				0, 1, 2, 3, 4: begin
					yr = 14'($urandom_range(0, 9999));
					mon = 4'($urandom_range(1, 12));
					dy = 5'($urandom_range(1, 28));
				end
				5, 6: begin
					yr = 14'($urandom_range(0, 9999));
					mon = 4'($urandom_range(1, 12));
				end
				7: begin
					yr = 14'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) :
						$urandom_range(9980, 9999));
				end
				8: ;
				9, 10, 11, 12, 13: dn = 22'($urandom_range(1, 3652500));
				14, 15: begin
					k = $urandom_range(1, 2500);
					dn = 22'(k * 1461 + $urandom_range(0, 2) - 1);
				end
				16: dn = 22'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 800) :
					$urandom_range(3651800, 3652510));
				default: ;
			endcase
			send_request(mode, dn, yr, mon, dy);
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d date-to-number and %0d number-to-date requests,",
			n_to_dn, n_to_date);
		$display("%0d of them outside the supported year or day number range.",
			n_out_of_range);
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
